FILE: hw/rtl/soks_pkg.sv
// ----------------------------------------------------------------------------
// soks_pkg: shared types and constants of the ordered keyword span block
// Widths, opcodes and the write/read bundles of the per-slot state store.
// ----------------------------------------------------------------------------
`default_nettype none

package soks_pkg;

    localparam int KEY_SLOTS = 16;
    localparam int WORD_BITS = 16;
    localparam int POS_BITS  = 20;
    localparam int SLOT_W    = $clog2(KEY_SLOTS);
    localparam int CNT_W     = 5;
    localparam int LEN_W     = POS_BITS + 1;

    localparam logic [LEN_W-1:0]    LEN_INF = {LEN_W{1'b1}};
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_WORD  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // write side of the per-slot store
    typedef struct packed {
        logic                pos_we;
        logic                len_we;
        logic [SLOT_W-1:0]   addr;
        logic [POS_BITS-1:0] pos;
        logic [LEN_W-1:0]    len;
    } store_wr_t;

    // registered read side of the per-slot store
    typedef struct packed {
        logic                len_valid;
        logic [POS_BITS-1:0] last;
        logic [LEN_W-1:0]    len;
    } store_rd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/soks_slot_store.sv
// ----------------------------------------------------------------------------
// soks_slot_store: per-slot last position and span length
// Two small memories with one write and one registered read port; a valid
// bit per slot marks span lengths written since the last clear.
// ----------------------------------------------------------------------------
`default_nettype none

module soks_slot_store (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            clear,
    input  wire logic [soks_pkg::SLOT_W-1:0]     rd_addr,
    input  wire soks_pkg::store_wr_t             wr,
    output soks_pkg::store_rd_t                  rd
);

    logic [soks_pkg::POS_BITS-1:0] pos_mem [soks_pkg::KEY_SLOTS];
    logic [soks_pkg::LEN_W-1:0]    len_mem [soks_pkg::KEY_SLOTS];
    logic [soks_pkg::KEY_SLOTS-1:0] valid_reg;
    logic [soks_pkg::KEY_SLOTS-1:0] valid_next;
    logic                           valid_q_reg;
    logic [soks_pkg::POS_BITS-1:0]  last_q_reg;
    logic [soks_pkg::LEN_W-1:0]     len_q_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr.len_we)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            valid_q_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.pos_we)
        begin
            pos_mem[wr.addr] <= wr.pos;
        end
        if (wr.len_we)
        begin
            len_mem[wr.addr] <= wr.len;
        end
        last_q_reg <= pos_mem[rd_addr];
        len_q_reg  <= len_mem[rd_addr];
    end

    // field order: len_valid, last, len
    assign rd = {valid_q_reg, last_q_reg, len_q_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/shortest_ordered_keyword_span_core.sv
// ----------------------------------------------------------------------------
// shortest_ordered_keyword_span_core: shortest ordered keyword span finder
// Tracks, over a paragraph of token ids, the shortest span holding the
// loaded keywords in slot order, and answers every beat with the best span.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one beat per item: opcode
//   selects a paragraph word, a keyword load into keyword_slot, or a clear
//   of all paragraph state. every input beat yields exactly one output
//   beat (out_valid/out_ready) with found, best_start, best_end and
//   position_overflow as they stand after that item.
//   cfg_we/cfg_wdata write keyword_count while the block is idle; 0 acts
//   as 1 and values above 16 act as 16.
// sequencing
//   a word that hits a keyword passes the scan of slots 0..n-1 through
//   one comparator, n being keyword_count clamped to 1..16, then fetch,
//   length update, best-span update and output load; a word that hits
//   nothing goes from the scan to the best-span update and output load;
//   all others go straight to the output load. in_ready is high only
//   when the sequencer is idle, again the cycle after the output loads.
// reset and stall
//   reset empties the paragraph state and sets keyword_count to 1; the
//   keyword table holds no defined value until loaded. a stalled receiver
//   holds the output register; the next input beat may be accepted and
//   worked on, and its result waits until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_ordered_keyword_span_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        opcode,
    input  wire logic [soks_pkg::WORD_BITS-1:0]    word_id,
    input  wire logic [soks_pkg::SLOT_W-1:0]       keyword_slot,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   found,
    output logic [soks_pkg::POS_BITS-1:0]          best_start,
    output logic [soks_pkg::POS_BITS-1:0]          best_end,
    output logic                                   position_overflow,
    input  wire logic                              cfg_we,
    input  wire logic [soks_pkg::CNT_W-1:0]        cfg_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_CALC  = 6'b001000,
        ST_BEST  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [soks_pkg::CNT_W-1:0] kc_reg;
    logic [soks_pkg::CNT_W-1:0] slots_n;
    logic [soks_pkg::CNT_W-1:0] last_slot;

    // keyword table, read one slot per cycle during the scan
    logic [soks_pkg::WORD_BITS-1:0] kw_mem [soks_pkg::KEY_SLOTS];
    logic [soks_pkg::WORD_BITS-1:0] kw_q_reg;
    logic                           kw_we;

    // item being worked on
    logic [soks_pkg::WORD_BITS-1:0] word_reg;

    // scan sequencer
    logic [soks_pkg::CNT_W-1:0]  scan_idx_reg;
    logic                        scan_issue;
    logic                        cmp_vld_reg;
    logic [soks_pkg::SLOT_W-1:0] cmp_slot_reg;
    logic                        hit_reg;
    logic [soks_pkg::SLOT_W-1:0] hit_slot_reg;

    // length update
    logic [soks_pkg::LEN_W-1:0]  new_len_reg;
    logic                        len_ok_reg;
    logic [soks_pkg::LEN_W:0]    span_sum;
    logic [soks_pkg::LEN_W:0]    span_cap;
    logic [soks_pkg::LEN_W-1:0]  calc_len;
    logic [soks_pkg::LEN_W-1:0]  first_full;

    // paragraph state
    logic [soks_pkg::LEN_W-1:0]    best_len_reg;
    logic [soks_pkg::POS_BITS-1:0] best_first_reg;
    logic [soks_pkg::POS_BITS-1:0] best_last_reg;
    logic                          have_span_reg;
    logic [soks_pkg::POS_BITS-1:0] pos_reg;
    logic                          sat_reg;

    // output register
    logic                          out_valid_reg;
    logic                          found_reg;
    logic [soks_pkg::POS_BITS-1:0] out_start_reg;
    logic [soks_pkg::POS_BITS-1:0] out_end_reg;
    logic                          out_ovf_reg;

    // per-slot store
    logic                          store_clear;
    logic [soks_pkg::SLOT_W-1:0]   store_rd_addr;
    soks_pkg::store_wr_t           store_wr;
    soks_pkg::store_rd_t           store_rd;

    logic in_beat;
    logic out_free;
    logic best_take;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // clamp keyword_count into 1..KEY_SLOTS
    always_comb
    begin
        slots_n = kc_reg;
        if (kc_reg == '0)
        begin
            slots_n = soks_pkg::CNT_W'(1);
        end
        else if (32'(kc_reg) > soks_pkg::KEY_SLOTS)
        begin
            slots_n = soks_pkg::CNT_W'(soks_pkg::KEY_SLOTS);
        end
    end

    assign last_slot  = slots_n - soks_pkg::CNT_W'(1);
    assign scan_issue = (scan_idx_reg < slots_n);

    // keyword loads happen straight at the input beat
    assign kw_we = in_beat && (opcode == soks_pkg::OP_LOAD)
                   && (32'(keyword_slot) < soks_pkg::KEY_SLOTS);

    always_ff @(posedge clk)
    begin
        if (kw_we)
        begin
            kw_mem[keyword_slot] <= word_id;
        end
        kw_q_reg <= kw_mem[scan_idx_reg[soks_pkg::SLOT_W-1:0]];
    end

    // span length ending at the hit slot: pos - last[s-1] + len[s-1],
    // capped at pos + 1
    assign span_sum = {2'b00, pos_reg} - {2'b00, store_rd.last} + {1'b0, store_rd.len};
    assign span_cap = {2'b00, pos_reg} + (soks_pkg::LEN_W + 1)'(1);

    always_comb
    begin
        if (span_sum > span_cap)
        begin
            calc_len = span_cap[soks_pkg::LEN_W-1:0];
        end
        else
        begin
            calc_len = span_sum[soks_pkg::LEN_W-1:0];
        end
    end

    assign first_full = {1'b0, pos_reg} + soks_pkg::LEN_W'(1) - new_len_reg;

    assign best_take = hit_reg && len_ok_reg
                       && ({1'b0, hit_slot_reg} == last_slot)
                       && (new_len_reg < best_len_reg);

    // store hookup: read the previous slot, write the hit slot in calc
    assign store_clear   = in_beat && (opcode == soks_pkg::OP_CLEAR);
    assign store_rd_addr = hit_slot_reg - soks_pkg::SLOT_W'(1);

    always_comb
    begin
        store_wr.pos_we = (state_reg == ST_CALC);
        store_wr.len_we = (state_reg == ST_CALC)
                          && ((hit_slot_reg == '0) || store_rd.len_valid);
        store_wr.addr   = hit_slot_reg;
        store_wr.pos    = pos_reg;
        store_wr.len    = (hit_slot_reg == '0) ? soks_pkg::LEN_W'(1) : calc_len;
    end

    soks_slot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (store_clear),
        .rd_addr (store_rd_addr),
        .wr      (store_wr),
        .rd      (store_rd)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if ((opcode == soks_pkg::OP_WORD) && !sat_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!scan_issue && !cmp_vld_reg)
                begin
                    state_next = hit_reg ? ST_FETCH : ST_BEST;
                end
            end
            ST_FETCH: state_next = ST_CALC;
            ST_CALC:  state_next = ST_BEST;
            ST_BEST:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kc_reg         <= soks_pkg::CNT_W'(1);
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            len_ok_reg     <= 1'b0;
            best_len_reg   <= soks_pkg::LEN_INF;
            best_first_reg <= '0;
            best_last_reg  <= '0;
            have_span_reg  <= 1'b0;
            pos_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                kc_reg <= cfg_wdata;
            end

            // load on a free output register, drop once the beat is taken
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    scan_idx_reg <= '0;
                    cmp_vld_reg  <= 1'b0;
                    hit_reg      <= 1'b0;
                    len_ok_reg   <= 1'b0;
                    if (store_clear)
                    begin
                        best_len_reg   <= soks_pkg::LEN_INF;
                        best_first_reg <= '0;
                        best_last_reg  <= '0;
                        have_span_reg  <= 1'b0;
                        pos_reg        <= '0;
                        sat_reg        <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    // read slot scan_idx, compare the slot read last cycle
                    cmp_vld_reg <= scan_issue;
                    if (scan_issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + soks_pkg::CNT_W'(1);
                    end
                    if (cmp_vld_reg && (kw_q_reg == word_reg))
                    begin
                        hit_reg <= 1'b1;
                    end
                end
                ST_CALC:
                begin
                    len_ok_reg <= store_wr.len_we;
                end
                ST_BEST:
                begin
                    if (best_take)
                    begin
                        best_len_reg   <= new_len_reg;
                        best_first_reg <= first_full[soks_pkg::POS_BITS-1:0];
                        best_last_reg  <= pos_reg;
                        have_span_reg  <= 1'b1;
                    end
                    if (pos_reg == soks_pkg::POS_MAX)
                    begin
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + soks_pkg::POS_BITS'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            word_reg <= word_id;
        end
        if (state_reg == ST_SCAN)
        begin
            cmp_slot_reg <= scan_idx_reg[soks_pkg::SLOT_W-1:0];
            if (cmp_vld_reg && (kw_q_reg == word_reg))
            begin
                // later slots override: highest matching slot wins
                hit_slot_reg <= cmp_slot_reg;
            end
        end
        if (state_reg == ST_CALC)
        begin
            new_len_reg <= store_wr.len;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            found_reg     <= have_span_reg;
            out_start_reg <= best_first_reg;
            out_end_reg   <= best_last_reg;
            out_ovf_reg   <= sat_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign found             = found_reg;
    assign best_start        = out_start_reg;
    assign best_end          = out_end_reg;
    assign position_overflow = out_ovf_reg;

    // saturation only leaves through a clear beat
    a_sat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg && !store_clear |=> sat_reg)
        else $error("position saturation dropped without a clear");

    // the best length never grows except through a clear
    a_best_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        !store_clear |=> best_len_reg <= $past(best_len_reg))
        else $error("best span length grew");

    // a found span never ends before it starts
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        have_span_reg |-> best_last_reg >= best_first_reg)
        else $error("best span end before start");

    // a hit is always within the slots in use
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg && (state_reg == ST_FETCH) |-> {1'b0, hit_slot_reg} <= last_slot)
        else $error("hit slot outside the keyword slots in use");

    // no new output beat while the previous one is still held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_end_reg))
        else $error("output beat overwritten while stalled");

endmodule

`default_nettype wire

FILE: test/keyword_span_checker.sv
// ----------------------------------------------------------------------------
// keyword_span_checker: result predictor and scoreboard for the span finder
// Watches the input, output and config ports, tracks its own copy of the
// keyword table and paragraph state, and checks every output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_span_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [1:0]                     opcode,
    input  wire logic [soks_pkg::WORD_BITS-1:0] word_id,
    input  wire logic [soks_pkg::SLOT_W-1:0]    keyword_slot,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic                           found,
    input  wire logic [soks_pkg::POS_BITS-1:0]  best_start,
    input  wire logic [soks_pkg::POS_BITS-1:0]  best_end,
    input  wire logic                           position_overflow,
    input  wire logic                           cfg_we,
    input  wire logic [soks_pkg::CNT_W-1:0]     cfg_wdata,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic                          found;
        logic [soks_pkg::POS_BITS-1:0] first_pos;
        logic [soks_pkg::POS_BITS-1:0] last_pos;
        logic                          overflow;
    } span_answer_t;

    logic [soks_pkg::CNT_W-1:0]     count_reg;
    logic [soks_pkg::WORD_BITS-1:0] kw_table  [soks_pkg::KEY_SLOTS];
    logic [soks_pkg::LEN_W-1:0]     seen_at   [soks_pkg::KEY_SLOTS];
    logic [soks_pkg::LEN_W-1:0]     chain_len [soks_pkg::KEY_SLOTS];
    logic [soks_pkg::LEN_W-1:0]     best_len;
    logic [soks_pkg::POS_BITS-1:0]  best_first;
    logic [soks_pkg::POS_BITS-1:0]  best_last;
    logic                           have_span;
    logic                           pos_saturated;
    logic [soks_pkg::POS_BITS-1:0]  word_pos;

    span_answer_t span_answers [$];
    span_answer_t want;
    int           answer_idx = 0;
    int           mismatches = 0;
    int           waiting    = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    task automatic report(input string what, input longint got, input longint wanted);
        $display("%0t span check: result %0d %s got %0h wanted %0h",
                 $time, answer_idx, what, got, wanted);
        mismatches++;
    endtask

    task automatic clear_paragraph();
        int k;
        for (k = 0; k < soks_pkg::KEY_SLOTS; k++)
        begin
            seen_at[k]   = soks_pkg::LEN_INF;
            chain_len[k] = soks_pkg::LEN_INF;
        end
        best_len      = soks_pkg::LEN_INF;
        best_first    = '0;
        best_last     = '0;
        have_span     = 1'b0;
        word_pos      = '0;
        pos_saturated = 1'b0;
    endtask

    task automatic take_word(input logic [soks_pkg::WORD_BITS-1:0] id);
        int                        used;
        int                        hit;
        int                        k;
        logic [63:0]               len;
        logic [soks_pkg::LEN_W-1:0] first_wide;
        used = int'(count_reg);
        if (used < 1)
            used = 1;
        if (used > soks_pkg::KEY_SLOTS)
            used = soks_pkg::KEY_SLOTS;
        hit = -1;
        if (!pos_saturated)
        begin
            // highest matching slot wins
            for (k = 0; k < used; k++)
                if (kw_table[k] == id)
                    hit = k;
            if (hit == 0)
                chain_len[0] = soks_pkg::LEN_W'(1);
            else if (hit > 0 && chain_len[hit-1] != soks_pkg::LEN_INF)
            begin
                len = 64'(word_pos) - 64'(seen_at[hit-1]) + 64'(chain_len[hit-1]);
                if (len > 64'(word_pos) + 64'd1)
                    len = 64'(word_pos) + 64'd1;
                chain_len[hit] = len[soks_pkg::LEN_W-1:0];
            end
            if (hit >= 0)
            begin
                seen_at[hit] = {1'b0, word_pos};
                if (hit == used - 1 && chain_len[hit] < best_len)
                begin
                    best_len   = chain_len[hit];
                    first_wide = {1'b0, word_pos} + 1'b1 - best_len;
                    best_first = first_wide[soks_pkg::POS_BITS-1:0];
                    best_last  = word_pos;
                    have_span  = 1'b1;
                end
            end
            if (word_pos == soks_pkg::POS_MAX)
                pos_saturated = 1'b1;
            else
                word_pos = word_pos + 1'b1;
        end
    endtask

    function automatic span_answer_t current_answer();
        span_answer_t a;
        a.found     = have_span;
        a.first_pos = have_span ? best_first : '0;
        a.last_pos  = have_span ? best_last : '0;
        a.overflow  = pos_saturated;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = 5'd1;
            for (int k = 0; k < soks_pkg::KEY_SLOTS; k++)
                kw_table[k] = '0;
            clear_paragraph();
            span_answers.delete();
            waiting <= 0;
        end
        else
        begin
            // output side first: an answer never leaves in its own input beat
            if (out_valid && out_ready)
            begin
                if (span_answers.size() == 0)
                    report("beat with nothing pending", 0, 0);
                else
                begin
                    want = span_answers.pop_front();
                    if (found !== want.found)
                        report("found", found, want.found);
                    if (best_start !== want.first_pos)
                        report("best_start", best_start, want.first_pos);
                    if (best_end !== want.last_pos)
                        report("best_end", best_end, want.last_pos);
                    if (position_overflow !== want.overflow)
                        report("position_overflow", position_overflow, want.overflow);
                end
                answer_idx++;
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    soks_pkg::OP_WORD:  take_word(word_id);
                    soks_pkg::OP_LOAD:  kw_table[keyword_slot] = word_id;
                    soks_pkg::OP_CLEAR: clear_paragraph();
                    default: ;
                endcase
                span_answers.push_back(current_answer());
            end
            if (cfg_we)
                count_reg = cfg_wdata;
            waiting <= span_answers.size();
        end
    end

endmodule

`default_nettype wire

FILE: test/shortest_ordered_keyword_span_core_tb.sv
// ----------------------------------------------------------------------------
// shortest_ordered_keyword_span_core_tb: top of the span finder testbench
// Loads the keyword table, walks through keyword counts from 0 to 31 and
// feeds ordered keyword runs mixed with noise, loads, clears and the spare
// opcode, under random idling on both channels. The checker scores results.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_ordered_keyword_span_core_tb;

    // spare opcode, answered without any state change
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         PHASE_BEATS = 45;
    localparam int         PHASES      = 14;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [1:0]                     opcode;
    logic [soks_pkg::WORD_BITS-1:0] word_id;
    logic [soks_pkg::SLOT_W-1:0]    keyword_slot;
    logic                           out_valid;
    logic                           out_ready;
    logic                           found;
    logic [soks_pkg::POS_BITS-1:0]  best_start;
    logic [soks_pkg::POS_BITS-1:0]  best_end;
    logic                           position_overflow;
    logic                           cfg_we;
    logic [soks_pkg::CNT_W-1:0]     cfg_wdata;

    int   fail_count;
    int   pending;

    // stimulus-side copy of the table, used only to build keyword runs
    logic [soks_pkg::WORD_BITS-1:0] kw [soks_pkg::KEY_SLOTS];
    int   slots_used = 1;
    int   beats_sent = 0;
    logic calm       = 1'b0;   // no idling on either side
    logic hold_req   = 1'b0;   // ask the receiver for one long hold-off
    logic hold_taken = 1'b0;

    shortest_ordered_keyword_span_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .word_id           (word_id),
        .keyword_slot      (keyword_slot),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .found             (found),
        .best_start        (best_start),
        .best_end          (best_end),
        .position_overflow (position_overflow),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata)
    );

    keyword_span_checker span_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .word_id           (word_id),
        .keyword_slot      (keyword_slot),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .found             (found),
        .best_start        (best_start),
        .best_end          (best_end),
        .position_overflow (position_overflow),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // noise word: either a random id or some keyword out of order
    function automatic logic [soks_pkg::WORD_BITS-1:0] noise_id();
        if ($urandom_range(1) == 0)
            return soks_pkg::WORD_BITS'($urandom);
        return kw[$urandom_range(soks_pkg::KEY_SLOTS-1)];
    endfunction

    // one input beat; valid stays high afterwards so back-to-back beats
    // never drop it, the next call lowers it only when a gap is wanted
    task automatic send_beat(input logic [1:0] op,
                             input logic [soks_pkg::WORD_BITS-1:0] id,
                             input logic [soks_pkg::SLOT_W-1:0] slot);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        word_id      <= id;
        keyword_slot <= slot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_word(input logic [soks_pkg::WORD_BITS-1:0] id);
        send_beat(soks_pkg::OP_WORD, id, soks_pkg::SLOT_W'($urandom));
    endtask

    task automatic load_slot(input logic [soks_pkg::SLOT_W-1:0] slot,
                             input logic [soks_pkg::WORD_BITS-1:0] id);
        send_beat(soks_pkg::OP_LOAD, id, slot);
        kw[slot] = id;
    endtask

    // sender pause: valid drops and nothing goes out until every answer is in;
    // the wait on pending starts once the checker has seen the last accepted beat
    task automatic wait_answered();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // keyword count is only written with nothing in flight
    task automatic set_count(input logic [soks_pkg::CNT_W-1:0] value);
        wait_answered();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        slots_used = (value == 0) ? 1 :
                     (value > soks_pkg::KEY_SLOTS) ? soks_pkg::KEY_SLOTS : int'(value);
    endtask

    // keyword run in slot order, with noise between and the odd keyword missing
    task automatic keyword_run();
        int k;
        for (k = 0; k < slots_used; k++)
        begin
            if ($urandom_range(99) < 25)
                send_word(noise_id());
            if ($urandom_range(99) >= 6)
                send_word(kw[k]);
        end
    endtask

    // receiver: random stalls, a calm mode and one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                // long hold: the block fills up and in_ready must drop
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (calm)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int                             phase;
        int                             k;
        int                             r;
        int                             goal;
        logic [soks_pkg::CNT_W-1:0]     count_plan [PHASES];
        logic [soks_pkg::WORD_BITS-1:0] id;

        count_plan = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd1,
                       5'd5, 5'd8, 5'd12, 5'd4, 5'd24, 5'd7, 5'd1};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = soks_pkg::OP_WORD;
        word_id      = '0;
        keyword_slot = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every slot loaded before the first word, so no lookup reads an
        // unwritten entry; slot 0 gets id zero and slot 15 the all-ones id
        for (k = 0; k < soks_pkg::KEY_SLOTS; k++)
        begin
            id = (k == 0) ? '0 :
                 (k == soks_pkg::KEY_SLOTS - 1) ? '1 : soks_pkg::WORD_BITS'(16'h5a00 + k);
            load_slot(soks_pkg::SLOT_W'(k), id);
        end

        // reset count of one: all-ones id is not in use, id zero completes a
        // one-word span, the repeat ties and must not replace it
        send_word('1);
        send_word('0);
        send_word('0);
        send_beat(OP_SPARE, '1, '1);
        send_beat(soks_pkg::OP_CLEAR, '0, '0);
        send_word(16'h1234);
        send_word('0);
        // reload mid-paragraph with a duplicate of slot 0 in slot 1
        load_slot(4'd1, '0);
        send_word('0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // last phase picks its count at random
            if (phase == PHASES - 1)
                count_plan[phase] = soks_pkg::CNT_W'($urandom_range(31));
            set_count(count_plan[phase]);
            calm = (phase == 6);
            if (phase == 4)
                hold_req <= 1'b1;
            if ($urandom_range(1) == 0)
                send_beat(soks_pkg::OP_CLEAR, soks_pkg::WORD_BITS'($urandom),
                          soks_pkg::SLOT_W'($urandom));
            goal = beats_sent + PHASE_BEATS;
            while (beats_sent < goal)
            begin
                r = $urandom_range(99);
                if (r < 60)
                    keyword_run();
                else if (r < 72)
                begin
                    repeat ($urandom_range(4, 1))
                        send_word(noise_id());
                end
                else if (r < 80)
                begin
                    // reload, often with an id already in the table
                    id = ($urandom_range(1) == 0) ? kw[$urandom_range(soks_pkg::KEY_SLOTS-1)]
                                                  : soks_pkg::WORD_BITS'($urandom);
                    load_slot(soks_pkg::SLOT_W'($urandom), id);
                end
                else if (r < 88)
                begin
                    send_beat(soks_pkg::OP_CLEAR, soks_pkg::WORD_BITS'($urandom),
                              soks_pkg::SLOT_W'($urandom));
                    if ($urandom_range(1) == 0)
                        wait_answered();
                end
                else if (r < 92)
                    send_beat(OP_SPARE, soks_pkg::WORD_BITS'($urandom),
                              soks_pkg::SLOT_W'($urandom));
                else
                    send_word(soks_pkg::WORD_BITS'($urandom));
            end
        end

        calm = 1'b0;
        wait_answered();
        // let any stray beat show up before the verdict
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("shortest_ordered_keyword_span_core_tb OK");
        else
            $display("shortest_ordered_keyword_span_core_tb NOT OK");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("shortest_ordered_keyword_span_core_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

FILE: shortest_ordered_keyword_span_core.f
hw/rtl/soks_pkg.sv
hw/rtl/soks_slot_store.sv
hw/rtl/shortest_ordered_keyword_span_core.sv
test/keyword_span_checker.sv
test/shortest_ordered_keyword_span_core_tb.sv
